FILE: rtl/ycm_pkg.sv
// Shared types, widths, register codes and constants for the YCbCr to RGB core.
// No dependencies.
package ycm_pkg;

  localparam int MAX_SAMPLE_BITS = 16;
  localparam int MIN_SAMPLE_BITS = 8;
  localparam int DEPTH_W = 5;
  localparam int MODE_W = 2;
  localparam int IDX_W = 3;
  localparam int COEF_W = 18;
  localparam int CFG_W = COEF_W;
  localparam int GAIN_W = 15;
  localparam int OPD_W = MAX_SAMPLE_BITS + 2;
  localparam int YCG_W = OPD_W + 2;
  localparam int Q_W = OPD_W + GAIN_W;
  localparam int PROD_W = COEF_W + Q_W;
  localparam int ACC_W = PROD_W + 2;
  localparam int FRAC_BITS = 14;
  localparam int ROUND_SHIFT = 2 * FRAC_BITS;
  localparam int QUOT_W = ACC_W - ROUND_SHIFT;

  localparam logic [MODE_W-1:0] MODE_GBR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_YCGCO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MATRIX = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MATRIX_ALT = 2'd3;

  localparam logic [IDX_W-1:0] REG_MATRIX_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_FULL_RANGE = 3'd1;
  localparam logic [IDX_W-1:0] REG_BIT_DEPTH = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEF_R_CR = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF_G_CB = 3'd4;
  localparam logic [IDX_W-1:0] REG_COEF_G_CR = 3'd5;
  localparam logic [IDX_W-1:0] REG_COEF_B_CB = 3'd6;

  localparam logic [GAIN_W-1:0] LUMA_GAIN = 15'd19151;
  localparam logic [GAIN_W-1:0] CHROMA_GAIN = 15'd18725;
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 15'd16384;

  localparam logic [DEPTH_W-1:0] DEPTH_RST = 5'd8;
  localparam logic signed [COEF_W-1:0] COEF_R_CR_RST = 18'sd22970;
  localparam logic signed [COEF_W-1:0] COEF_G_CB_RST = -18'sd5638;
  localparam logic signed [COEF_W-1:0] COEF_G_CR_RST = -18'sd11700;
  localparam logic signed [COEF_W-1:0] COEF_B_CB_RST = 18'sd29032;

  typedef logic [MAX_SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OPD_W-1:0] opd_t;
  typedef logic signed [YCG_W-1:0] ycg_t;
  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic full;
    logic [DEPTH_W-1:0] depth;
  } cfg_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] r_cr;
    logic signed [COEF_W-1:0] g_cb;
    logic signed [COEF_W-1:0] g_cr;
    logic signed [COEF_W-1:0] b_cb;
  } coef_t;

  // Per-item side info that rides along with the datapath.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DEPTH_W-1:0] depth;
    sample_t alpha;
  } ctl_t;

  typedef struct packed {
    ycg_t r;
    ycg_t g;
    ycg_t b;
  } ycg_set_t;

  typedef struct packed {
    opd_t ya;
    opd_t cba;
    opd_t cra;
    logic [GAIN_W-1:0] gy;
    logic [GAIN_W-1:0] gc;
    ycg_set_t ycg;
  } opd_set_t;

  typedef struct packed {
    q_t yq;
    q_t cbq;
    q_t crq;
    prod_t p_r_cr;
    prod_t p_g_cb;
    prod_t p_g_cr;
    prod_t p_b_cb;
    ycg_set_t ycg;
  } prod_set_t;

endpackage

FILE: rtl/ycm_prep.sv
// Stage 1: depth clamp, offset removal, gain select and YCgCo sums.
// Depends on ycm_pkg.
module ycm_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  ycm_pkg::cfg_t     cfg,
  input  logic              in_valid,
  input  ycm_pkg::sample_t  luma,
  input  ycm_pkg::sample_t  chroma_blue,
  input  ycm_pkg::sample_t  chroma_red,
  input  ycm_pkg::sample_t  alpha,
  output logic              valid_s1,
  output ycm_pkg::ctl_t     ctl_s1,
  output ycm_pkg::opd_set_t opd_s1
);

  logic [ycm_pkg::DEPTH_W-1:0] depth_c;
  logic [ycm_pkg::DEPTH_W-1:0] off_sh;
  logic [ycm_pkg::DEPTH_W-1:0] half_sh;
  ycm_pkg::sample_t            off_v;
  ycm_pkg::sample_t            half_v;
  ycm_pkg::sample_t            luma_sub;
  ycm_pkg::sample_t            chroma_sub;
  ycm_pkg::opd_set_t           opd_nxt;
  ycm_pkg::ctl_t               ctl_nxt;
  logic                        valid_r;
  ycm_pkg::ctl_t               ctl_r;
  ycm_pkg::opd_set_t           opd_r;

  always_comb begin
    if (cfg.depth < ycm_pkg::DEPTH_W'(ycm_pkg::MIN_SAMPLE_BITS)) begin
      depth_c = ycm_pkg::DEPTH_W'(ycm_pkg::MIN_SAMPLE_BITS);
    end else if (cfg.depth > ycm_pkg::DEPTH_W'(ycm_pkg::MAX_SAMPLE_BITS)) begin
      depth_c = ycm_pkg::DEPTH_W'(ycm_pkg::MAX_SAMPLE_BITS);
    end else begin
      depth_c = cfg.depth;
    end
    off_sh  = depth_c - ycm_pkg::DEPTH_W'(ycm_pkg::MIN_SAMPLE_BITS);
    half_sh = depth_c - ycm_pkg::DEPTH_W'(1);
    off_v   = ycm_pkg::sample_t'(16) << off_sh;
    half_v  = ycm_pkg::sample_t'(1) << half_sh;

    luma_sub = (cfg.mode != ycm_pkg::MODE_YCGCO && !cfg.full) ? off_v : '0;
    if (cfg.mode == ycm_pkg::MODE_GBR) begin
      chroma_sub = cfg.full ? '0 : off_v;
    end else begin
      chroma_sub = half_v;
    end

    opd_nxt.ya  = $signed({2'b00, luma}) - $signed({2'b00, luma_sub});
    opd_nxt.cba = $signed({2'b00, chroma_blue}) - $signed({2'b00, chroma_sub});
    opd_nxt.cra = $signed({2'b00, chroma_red}) - $signed({2'b00, chroma_sub});
    opd_nxt.gy  = cfg.full ? ycm_pkg::UNITY_GAIN : ycm_pkg::LUMA_GAIN;
    opd_nxt.gc  = cfg.full ? ycm_pkg::UNITY_GAIN : ycm_pkg::CHROMA_GAIN;
    opd_nxt.ycg.r = ycm_pkg::ycg_t'(opd_nxt.ya) - ycm_pkg::ycg_t'(opd_nxt.cba)
                  + ycm_pkg::ycg_t'(opd_nxt.cra);
    opd_nxt.ycg.g = ycm_pkg::ycg_t'(opd_nxt.ya) + ycm_pkg::ycg_t'(opd_nxt.cba);
    opd_nxt.ycg.b = ycm_pkg::ycg_t'(opd_nxt.ya) - ycm_pkg::ycg_t'(opd_nxt.cba)
                  - ycm_pkg::ycg_t'(opd_nxt.cra);

    ctl_nxt.mode  = cfg.mode;
    ctl_nxt.depth = depth_c;
    ctl_nxt.alpha = alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r <= ctl_nxt;
    opd_r <= opd_nxt;
  end

  assign valid_s1 = valid_r;
  assign ctl_s1   = ctl_r;
  assign opd_s1   = opd_r;

endmodule

FILE: rtl/ycm_mult.sv
// Stages 2 and 3: gain multiply into Q14, then coefficient products.
// Depends on ycm_pkg.
module ycm_mult (
  input  logic               clk,
  input  logic               rst_n,
  input  ycm_pkg::coef_t     coef,
  input  logic               valid_s1,
  input  ycm_pkg::ctl_t      ctl_s1,
  input  ycm_pkg::opd_set_t  opd_s1,
  output logic               valid_s3,
  output ycm_pkg::ctl_t      ctl_s3,
  output ycm_pkg::prod_set_t prod_s3
);

  logic               valid_s2_r;
  ycm_pkg::ctl_t      ctl_s2_r;
  ycm_pkg::q_t        yq_s2_r;
  ycm_pkg::q_t        cbq_s2_r;
  ycm_pkg::q_t        crq_s2_r;
  ycm_pkg::ycg_set_t  ycg_s2_r;
  logic               valid_s3_r;
  ycm_pkg::ctl_t      ctl_s3_r;
  ycm_pkg::prod_set_t prod_s3_r;
  ycm_pkg::q_t        yq_nxt;
  ycm_pkg::q_t        cbq_nxt;
  ycm_pkg::q_t        crq_nxt;
  ycm_pkg::prod_set_t prod_nxt;

  always_comb begin
    yq_nxt  = ycm_pkg::q_t'(opd_s1.ya) * ycm_pkg::q_t'($signed({1'b0, opd_s1.gy}));
    cbq_nxt = ycm_pkg::q_t'(opd_s1.cba) * ycm_pkg::q_t'($signed({1'b0, opd_s1.gc}));
    crq_nxt = ycm_pkg::q_t'(opd_s1.cra) * ycm_pkg::q_t'($signed({1'b0, opd_s1.gc}));
  end

  always_comb begin
    prod_nxt.yq     = yq_s2_r;
    prod_nxt.cbq    = cbq_s2_r;
    prod_nxt.crq    = crq_s2_r;
    prod_nxt.p_r_cr = ycm_pkg::prod_t'(coef.r_cr) * ycm_pkg::prod_t'(crq_s2_r);
    prod_nxt.p_g_cb = ycm_pkg::prod_t'(coef.g_cb) * ycm_pkg::prod_t'(cbq_s2_r);
    prod_nxt.p_g_cr = ycm_pkg::prod_t'(coef.g_cr) * ycm_pkg::prod_t'(crq_s2_r);
    prod_nxt.p_b_cb = ycm_pkg::prod_t'(coef.b_cb) * ycm_pkg::prod_t'(cbq_s2_r);
    prod_nxt.ycg    = ycg_s2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_s2_r <= 1'b0;
      valid_s3_r <= 1'b0;
    end else begin
      valid_s2_r <= valid_s1;
      valid_s3_r <= valid_s2_r;
    end
  end

  always_ff @(posedge clk) begin
    ctl_s2_r  <= ctl_s1;
    yq_s2_r   <= yq_nxt;
    cbq_s2_r  <= cbq_nxt;
    crq_s2_r  <= crq_nxt;
    ycg_s2_r  <= opd_s1.ycg;
    ctl_s3_r  <= ctl_s2_r;
    prod_s3_r <= prod_nxt;
  end

  assign valid_s3 = valid_s3_r;
  assign ctl_s3   = ctl_s3_r;
  assign prod_s3  = prod_s3_r;

endmodule

FILE: rtl/ycm_round.sv
// Stages 4 and 5: per-mode accumulate with Q28 rounding, then clip to bit depth.
// Depends on ycm_pkg.
module ycm_round (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_s3,
  input  ycm_pkg::ctl_t      ctl_s3,
  input  ycm_pkg::prod_set_t prod_s3,
  output logic               out_valid,
  output ycm_pkg::sample_t   red,
  output ycm_pkg::sample_t   green,
  output ycm_pkg::sample_t   blue,
  output ycm_pkg::sample_t   alpha
);

  localparam ycm_pkg::acc_t RND = ycm_pkg::acc_t'(1) <<< (ycm_pkg::ROUND_SHIFT - 1);

  logic             valid_s4_r;
  ycm_pkg::ctl_t    ctl_s4_r;
  ycm_pkg::acc_t    acc_r_s4_r;
  ycm_pkg::acc_t    acc_g_s4_r;
  ycm_pkg::acc_t    acc_b_s4_r;
  ycm_pkg::acc_t    acc_r_nxt;
  ycm_pkg::acc_t    acc_g_nxt;
  ycm_pkg::acc_t    acc_b_nxt;
  ycm_pkg::acc_t    y28;
  logic             valid_out_r;
  ycm_pkg::sample_t red_r;
  ycm_pkg::sample_t green_r;
  ycm_pkg::sample_t blue_r;
  ycm_pkg::sample_t alpha_r;
  ycm_pkg::sample_t red_nxt;
  ycm_pkg::sample_t green_nxt;
  ycm_pkg::sample_t blue_nxt;
  logic [ycm_pkg::MAX_SAMPLE_BITS:0] lim;

  function automatic ycm_pkg::sample_t clip(input ycm_pkg::acc_t t,
                                            input logic [ycm_pkg::MAX_SAMPLE_BITS:0] lim_v);
    logic [ycm_pkg::QUOT_W-1:0] q;
    q = t[ycm_pkg::ACC_W-1:ycm_pkg::ROUND_SHIFT];
    if (t[ycm_pkg::ACC_W-1]) begin
      clip = '0;
    end else if (q > ycm_pkg::QUOT_W'(lim_v)) begin
      clip = lim_v[ycm_pkg::MAX_SAMPLE_BITS-1:0];
    end else begin
      clip = q[ycm_pkg::MAX_SAMPLE_BITS-1:0];
    end
  endfunction

  always_comb begin
    y28 = ycm_pkg::acc_t'(prod_s3.yq) <<< ycm_pkg::FRAC_BITS;
    case (ctl_s3.mode)
      ycm_pkg::MODE_GBR: begin
        acc_r_nxt = (ycm_pkg::acc_t'(prod_s3.crq) <<< ycm_pkg::FRAC_BITS) + RND;
        acc_g_nxt = y28 + RND;
        acc_b_nxt = (ycm_pkg::acc_t'(prod_s3.cbq) <<< ycm_pkg::FRAC_BITS) + RND;
      end
      ycm_pkg::MODE_YCGCO: begin
        acc_r_nxt = ycm_pkg::acc_t'(prod_s3.ycg.r) <<< ycm_pkg::ROUND_SHIFT;
        acc_g_nxt = ycm_pkg::acc_t'(prod_s3.ycg.g) <<< ycm_pkg::ROUND_SHIFT;
        acc_b_nxt = ycm_pkg::acc_t'(prod_s3.ycg.b) <<< ycm_pkg::ROUND_SHIFT;
      end
      default: begin
        acc_r_nxt = y28 + ycm_pkg::acc_t'(prod_s3.p_r_cr) + RND;
        acc_g_nxt = y28 + ycm_pkg::acc_t'(prod_s3.p_g_cb)
                  + ycm_pkg::acc_t'(prod_s3.p_g_cr) + RND;
        acc_b_nxt = y28 + ycm_pkg::acc_t'(prod_s3.p_b_cb) + RND;
      end
    endcase
  end

  always_comb begin
    lim       = ({{ycm_pkg::MAX_SAMPLE_BITS{1'b0}}, 1'b1} << ctl_s4_r.depth)
              - {{ycm_pkg::MAX_SAMPLE_BITS{1'b0}}, 1'b1};
    red_nxt   = clip(acc_r_s4_r, lim);
    green_nxt = clip(acc_g_s4_r, lim);
    blue_nxt  = clip(acc_b_s4_r, lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_s4_r  <= 1'b0;
      valid_out_r <= 1'b0;
    end else begin
      valid_s4_r  <= valid_s3;
      valid_out_r <= valid_s4_r;
    end
  end

  always_ff @(posedge clk) begin
    ctl_s4_r   <= ctl_s3;
    acc_r_s4_r <= acc_r_nxt;
    acc_g_s4_r <= acc_g_nxt;
    acc_b_s4_r <= acc_b_nxt;
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    blue_r     <= blue_nxt;
    alpha_r    <= ctl_s4_r.alpha;
  end

  assign out_valid = valid_out_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;
  assign alpha     = alpha_r;

endmodule

FILE: rtl/ycbcr_to_rgb_multi_matrix_core.sv
// Top level of the YCbCr to RGB core: config registers and the five-stage pipeline.
// Depends on ycm_pkg, ycm_prep, ycm_mult, ycm_round.
//
//   channel   handshake           payload
//   input     start / busy        in_luma, in_chroma_blue, in_chroma_red, in_alpha_in
//   result    out_valid strobe    out_red, out_green, out_blue, out_alpha_out
//   config    cfg_we              cfg_index, cfg_wdata
//
// One item per clock; out_valid rises once an item has passed the five register stages
// (prep, gain multiply, coefficient multiply, accumulate, clip). busy is always low.
// Synchronous reset clears the valid bits and loads the register defaults. Results are
// not held back by the receiver.
module ycbcr_to_rgb_multi_matrix_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [15:0]                  in_luma,
  input  logic [15:0]                  in_chroma_blue,
  input  logic [15:0]                  in_chroma_red,
  input  logic [15:0]                  in_alpha_in,
  output logic                         out_valid,
  output logic [15:0]                  out_red,
  output logic [15:0]                  out_green,
  output logic [15:0]                  out_blue,
  output logic [15:0]                  out_alpha_out,
  input  logic                         cfg_we,
  input  logic [ycm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [ycm_pkg::CFG_W-1:0]    cfg_wdata
);

  ycm_pkg::cfg_t      cfg_r;
  ycm_pkg::coef_t     coef_r;
  logic               valid_s1;
  ycm_pkg::ctl_t      ctl_s1;
  ycm_pkg::opd_set_t  opd_s1;
  logic               valid_s3;
  ycm_pkg::ctl_t      ctl_s3;
  ycm_pkg::prod_set_t prod_s3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= ycm_pkg::MODE_MATRIX;
      cfg_r.full  <= 1'b1;
      cfg_r.depth <= ycm_pkg::DEPTH_RST;
      coef_r.r_cr <= ycm_pkg::COEF_R_CR_RST;
      coef_r.g_cb <= ycm_pkg::COEF_G_CB_RST;
      coef_r.g_cr <= ycm_pkg::COEF_G_CR_RST;
      coef_r.b_cb <= ycm_pkg::COEF_B_CB_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ycm_pkg::REG_MATRIX_MODE: cfg_r.mode  <= cfg_wdata[ycm_pkg::MODE_W-1:0];
        ycm_pkg::REG_FULL_RANGE:  cfg_r.full  <= cfg_wdata[0];
        ycm_pkg::REG_BIT_DEPTH:   cfg_r.depth <= cfg_wdata[ycm_pkg::DEPTH_W-1:0];
        ycm_pkg::REG_COEF_R_CR:   coef_r.r_cr <= $signed(cfg_wdata);
        ycm_pkg::REG_COEF_G_CB:   coef_r.g_cb <= $signed(cfg_wdata);
        ycm_pkg::REG_COEF_G_CR:   coef_r.g_cr <= $signed(cfg_wdata);
        ycm_pkg::REG_COEF_B_CB:   coef_r.b_cb <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  ycm_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (start && !busy),
    .luma        (in_luma),
    .chroma_blue (in_chroma_blue),
    .chroma_red  (in_chroma_red),
    .alpha       (in_alpha_in),
    .valid_s1    (valid_s1),
    .ctl_s1      (ctl_s1),
    .opd_s1      (opd_s1)
  );

  ycm_mult u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef_r),
    .valid_s1 (valid_s1),
    .ctl_s1   (ctl_s1),
    .opd_s1   (opd_s1),
    .valid_s3 (valid_s3),
    .ctl_s3   (ctl_s3),
    .prod_s3  (prod_s3)
  );

  ycm_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_s3  (valid_s3),
    .ctl_s3    (ctl_s3),
    .prod_s3   (prod_s3),
    .out_valid (out_valid),
    .red       (out_red),
    .green     (out_green),
    .blue      (out_blue),
    .alpha     (out_alpha_out)
  );

endmodule
